FILE: sv/lkv_pkg.sv
package lkv_pkg;

    // Default store depth
    localparam int ENTRIES_DEF = 16;

    // Fixed field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in tuser
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_EMIT
    } state_t;

    // Kind of recency update swept over the ranks
    typedef enum logic {
        UPD_PROMOTE,
        UPD_INSERT
    } upd_mode_t;

endpackage

FILE: sv/lkv_ram.sv
module lkv_ram #(
    parameter int WIDTH = lkv_pkg::KEY_W,
    parameter int DEPTH = lkv_pkg::ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/lru_key_value_cache.sv
// Flow: a get miss passes key scan, decision and output after the input transfer;
// every other item also passes a rank sweep (key scan, decision, rank sweep, output).
// Items are taken one at a time: a new item is accepted only once the last result
// is in the output register. The compare unit scans one entry per cycle.
// Reset: asynchronous, active low; clears all valid bits and the occupancy at once
// and sets capacity to 16. Key, value and rank memories are not cleared.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: capacity
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_tuser,   // [0] func
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]  m_tuser    // [0] hit, [1] evicted
);

    localparam int KW = lkv_pkg::KEY_W;
    localparam int VW = lkv_pkg::VAL_W;
    localparam int CPW = lkv_pkg::CAP_W;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int OW = (CW > CPW) ? CW : CPW;

    // Sequencer
    lkv_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            chk_valid_reg, chk_valid_next;
    logic [IW-1:0]   chk_idx_reg;
    logic            scan_proc, decide_go, upd_proc, emit_load, in_xfer;

    // Captured item and configuration
    logic            func_reg;
    logic [KW-1:0]   key_reg;
    logic [VW-1:0]   val_reg;
    logic [CPW-1:0]  cap_reg;

    // Store state held in flip-flops
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [CW-1:0]      occ_reg;

    // Scan results
    logic            have_reg;
    logic [IW-1:0]   found_idx_reg;
    logic [VW-1:0]   found_val_reg;
    logic [RW-1:0]   found_rank_reg;
    logic            vic_found_reg;
    logic [IW-1:0]   vic_idx_reg;
    logic [RW-1:0]   vic_rank_reg;
    logic [KW-1:0]   vic_key_reg;
    logic            free_found_reg;
    logic [IW-1:0]   free_idx_reg;

    // Decision
    lkv_pkg::upd_mode_t mode_reg;
    logic [IW-1:0]   slot_reg;
    logic            res_hit_reg, res_ev_reg;
    logic [VW-1:0]   res_rv_reg;
    logic [KW-1:0]   res_ek_reg;

    // Output register
    logic            m_tvalid_reg;
    logic            out_hit_reg, out_ev_reg;
    logic [VW-1:0]   out_rv_reg;
    logic [KW-1:0]   out_ek_reg;

    // Memory ports
    logic [KW-1:0]   key_q;
    logic [VW-1:0]   val_q;
    logic [RW-1:0]   rank_q;
    logic            key_we, val_we, rank_we;
    logic [IW-1:0]   val_waddr;
    logic [RW-1:0]   rank_wdata;
    logic [IW-1:0]   rd_addr;

    // Decision helpers
    logic [OW-1:0]   cap_ext, eff_cap, occ_ext;
    logic            do_evict, is_put, cur_valid;
    logic [IW-1:0]   ins_slot;

    assign in_xfer = s_tvalid && s_tready;
    assign rd_addr = cnt_reg[IW-1:0];
    assign is_put = (func_reg == lkv_pkg::FUNC_PUT);
    assign cur_valid = valid_reg[chk_idx_reg];

    // Effective capacity: zero counts as one, saturate at the depth
    assign cap_ext = OW'(cap_reg);
    assign occ_ext = OW'(occ_reg);
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = OW'(1);
        end
        else if (cap_ext > OW'(ENTRIES))
        begin
            eff_cap = OW'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign do_evict = (occ_ext >= eff_cap) && (occ_reg != '0);

    // Insert into the lowest free slot, counting the victim as freed
    assign ins_slot = (free_found_reg && (!do_evict || (free_idx_reg < vic_idx_reg)))
                      ? free_idx_reg : vic_idx_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkv_pkg::S_IDLE;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // Next state and strobes
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        chk_valid_next = 1'b0;
        s_tready       = 1'b0;
        scan_proc      = 1'b0;
        decide_go      = 1'b0;
        upd_proc       = 1'b0;
        emit_load      = 1'b0;
        case (state_reg)
            lkv_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid)
                begin
                    state_next = lkv_pkg::S_SCAN;
                end
            end
            lkv_pkg::S_SCAN:
            begin
                scan_proc = chk_valid_reg;
                if (cnt_reg != CW'(ENTRIES))
                begin
                    chk_valid_next = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = lkv_pkg::S_DECIDE;
                end
            end
            lkv_pkg::S_DECIDE:
            begin
                decide_go = 1'b1;
                cnt_next  = '0;
                if (!is_put && !have_reg)
                begin
                    state_next = lkv_pkg::S_EMIT;
                end
                else
                begin
                    state_next = lkv_pkg::S_UPDATE;
                end
            end
            lkv_pkg::S_UPDATE:
            begin
                upd_proc = chk_valid_reg;
                if (cnt_reg != CW'(ENTRIES))
                begin
                    chk_valid_next = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = lkv_pkg::S_EMIT;
                end
            end
            lkv_pkg::S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    emit_load  = 1'b1;
                    state_next = lkv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lkv_pkg::S_IDLE;
            end
        endcase
    end

    // Track which entry the returning read data belongs to
    always_ff @(posedge clk)
    begin
        chk_idx_reg <= cnt_reg[IW-1:0];
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkv_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= s_tuser[0];
            key_reg  <= s_tdata[KW-1:0];
            val_reg  <= s_tdata[KW+VW-1:KW];
        end
    end

    // Scan flags: clear on transfer, set by the compare unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg       <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            have_reg       <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (scan_proc)
        begin
            if (cur_valid && (key_q == key_reg))
            begin
                have_reg <= 1'b1;
            end
            if (cur_valid)
            begin
                vic_found_reg <= 1'b1;
            end
            else
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Compare unit: first key match, oldest valid entry, first free slot
    always_ff @(posedge clk)
    begin
        if (scan_proc)
        begin
            if (cur_valid && (key_q == key_reg) && !have_reg)
            begin
                found_idx_reg  <= chk_idx_reg;
                found_val_reg  <= val_q;
                found_rank_reg <= rank_q;
            end
            if (cur_valid && (!vic_found_reg || (rank_q > vic_rank_reg)))
            begin
                vic_idx_reg  <= chk_idx_reg;
                vic_rank_reg <= rank_q;
                vic_key_reg  <= key_q;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_idx_reg <= chk_idx_reg;
            end
        end
    end

    // Next valid bits: drop the victim, then mark the insert slot
    always_comb
    begin
        valid_next = valid_reg;
        if (do_evict)
        begin
            valid_next[vic_idx_reg] = 1'b0;
        end
        valid_next[ins_slot] = 1'b1;
    end

    // Valid bits and occupancy: evict and insert on a put of a new key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else if (decide_go && is_put && !have_reg)
        begin
            valid_reg <= valid_next;
            if (!do_evict)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
        end
    end

    // Result and rank sweep setup
    always_ff @(posedge clk)
    begin
        if (decide_go)
        begin
            mode_reg    <= have_reg ? lkv_pkg::UPD_PROMOTE : lkv_pkg::UPD_INSERT;
            slot_reg    <= ins_slot;
            res_hit_reg <= have_reg;
            if (is_put)
            begin
                res_rv_reg <= '0;
            end
            else if (have_reg)
            begin
                res_rv_reg <= found_val_reg;
            end
            else
            begin
                res_rv_reg <= '1;
            end
            res_ev_reg <= is_put && !have_reg && do_evict;
            res_ek_reg <= (is_put && !have_reg && do_evict) ? vic_key_reg : '0;
        end
    end

    // Memory writes
    assign key_we    = decide_go && is_put && !have_reg;
    assign val_we    = decide_go && is_put;
    assign val_waddr = have_reg ? found_idx_reg : ins_slot;
    assign rank_we   = upd_proc;

    // New rank for the entry under the sweep
    always_comb
    begin
        rank_wdata = rank_q;
        if (mode_reg == lkv_pkg::UPD_INSERT)
        begin
            if (chk_idx_reg == slot_reg)
            begin
                rank_wdata = '0;
            end
            else if (cur_valid)
            begin
                rank_wdata = rank_q + 1'b1;
            end
        end
        else
        begin
            if (chk_idx_reg == found_idx_reg)
            begin
                rank_wdata = '0;
            end
            else if (cur_valid && (rank_q < found_rank_reg))
            begin
                rank_wdata = rank_q + 1'b1;
            end
        end
    end

    lkv_ram #(
        .WIDTH (KW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (ins_slot),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (key_q)
    );

    lkv_ram #(
        .WIDTH (VW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (val_q)
    );

    lkv_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (chk_idx_reg),
        .wdata (rank_wdata),
        .raddr (rd_addr),
        .rdata (rank_q)
    );

    // Output register: hold until the result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_hit_reg <= res_hit_reg;
            out_rv_reg  <= res_rv_reg;
            out_ev_reg  <= res_ev_reg;
            out_ek_reg  <= res_ek_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_ek_reg, out_rv_reg};
    assign m_tuser  = {out_ev_reg, out_hit_reg};

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(ENTRIES))
        else $error("occupancy exceeds store depth");

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy disagrees with valid bits");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == lkv_pkg::S_SCAN) && (cnt_reg == '0))
        else $error("scan did not start after input transfer");

    a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (decide_go && is_put && !have_reg) |-> (free_found_reg || do_evict))
        else $error("insert without a free or evicted slot");
`endif

endmodule
